/* sv/kcr_pkg.sv */
// Shared types, constants and saturation helpers for the collision resolver.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package kcr_pkg;

   localparam int FRAC_BITS_DEF = 16;

   localparam logic signed [31:0] MAX32 = 32'sh7FFF_FFFF;
   localparam logic signed [31:0] MIN32 = 32'sh8000_0000;
   localparam logic signed [63:0] MAX64 = 64'sh7FFF_FFFF_FFFF_FFFF;
   localparam logic signed [63:0] MIN64 = 64'sh8000_0000_0000_0000;

   // operand pairs for the shared multiplier
   typedef enum logic [3:0] {
      MS_VX_MX, MS_VY_MY, MS_OX_MX, MS_OY_MY, MS_MX_MX, MS_MY_MY,
      MS_PX_MX, MS_PY_MY, MS_MX_DDP, MS_MY_DDP, MS_MX_R, MS_MY_R,
      MS_CX_MY, MS_CY_MX
   } mul_sel_type;

   typedef enum logic [2:0] {
      DD_NONE, DD_SV, DD_SO, DD_N, DD_D
   } dot_dst_type;

   typedef enum logic [1:0] {
      DS_P, DS_Q, DS_R
   } div_src_type;

   typedef struct packed {
      logic        capture;
      logic        resolve;
      mul_sel_type mul_sel;
      logic        hold;
      dot_dst_type dot_dst;
      logic        div_start;
      div_src_type div_src;
      logic        div_load;
      logic        p_default;
      logic        ddp_load;
      logic        pos_x_load;
      logic        pos_y_load;
      logic        velr_x_load;
      logic        velr_y_load;
      logic        vel_neg_load;
   } kcr_cmd_type;

   typedef struct packed {
      logic skip;
      logic total_zero;
      logic vel_zero;
      logic v_pos;
      logic cross_ne;
      logic div_done;
   } kcr_status_type;

   function automatic logic signed [31:0] sat32(input logic signed [65:0] x);
      logic signed [31:0] r;
      if (x > 66'(MAX32)) r = MAX32;
      else if (x < 66'(MIN32)) r = MIN32;
      else r = x[31:0];
      return r;
   endfunction

   function automatic logic signed [63:0] sat64(input logic signed [64:0] x);
      logic signed [63:0] r;
      if (x > 65'(MAX64)) r = MAX64;
      else if (x < 65'(MIN64)) r = MIN64;
      else r = x[63:0];
      return r;
   endfunction

endpackage

`default_nettype wire

/* sv/kcr_div.sv */
// Iterative fixed-point divider: floor(num * 2^F / den), capped at 2^32.
// One quotient bit per cycle. Depends on kcr_pkg.
`timescale 1ns / 1ps
`default_nettype none

module kcr_div #(
   parameter int FRAC_BITS = kcr_pkg::FRAC_BITS_DEF
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        start,
   input  wire logic [63:0] num,
   input  wire logic [63:0] den,
   output logic             done,
   output logic [32:0]      quo
);
   import kcr_pkg::*;

   logic                   busy_ff, busy_in;
   logic                   done_ff, done_in;
   logic [5:0]             cnt_ff, cnt_in;
   logic [63:0]            rem_ff, rem_in;
   logic [31:0]            low_ff, low_in;
   logic [32:0]            quo_ff, quo_in;
   logic [63+FRAC_BITS:0]  num_sh;
   logic [31+FRAC_BITS:0]  hi;
   logic [64:0]            trial;
   logic                   ge;

   assign num_sh = {num, FRAC_BITS'(0)};
   assign hi     = num_sh[63+FRAC_BITS:32];
   assign trial  = {rem_ff, low_ff[31]};
   assign ge     = trial >= {1'b0, den};

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      low_in  = low_ff;
      quo_in  = quo_ff;
      if (start) begin
         if (64'(hi) >= den) begin
            // quotient would reach 2^32: cap
            quo_in  = {1'b1, 32'd0};
            done_in = 1'b1;
            busy_in = 1'b0;
         end else begin
            rem_in  = 64'(hi);
            low_in  = num_sh[31:0];
            quo_in  = '0;
            cnt_in  = 6'd32;
            busy_in = 1'b1;
         end
      end else if (busy_ff) begin
         rem_in = ge ? 64'(trial - {1'b0, den}) : trial[63:0];
         low_in = {low_ff[30:0], 1'b0};
         quo_in = {quo_ff[31:0], ge};
         cnt_in = cnt_ff - 6'd1;
         if (cnt_ff == 6'd1) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      rem_ff <= rem_in;
      low_ff <= low_in;
      quo_ff <= quo_in;
   end

   assign done = done_ff;
   assign quo  = quo_ff;

endmodule

`default_nettype wire

/* sv/kcr_dp.sv */
// Datapath: operand and correction registers, shared multiplier, dot sums,
// divider and output registers. Depends on kcr_pkg and kcr_div.
`timescale 1ns / 1ps
`default_nettype none

module kcr_dp #(
   parameter int FRAC_BITS = kcr_pkg::FRAC_BITS_DEF
) (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire kcr_pkg::kcr_cmd_type      cmd,
   output kcr_pkg::kcr_status_type        status,
   input  wire logic signed [31:0]        req_self_vel_x,
   input  wire logic signed [31:0]        req_self_vel_y,
   input  wire logic signed [31:0]        req_self_pos_x,
   input  wire logic signed [31:0]        req_self_pos_y,
   input  wire logic signed [31:0]        req_mtv_x,
   input  wire logic signed [31:0]        req_mtv_y,
   input  wire logic signed [31:0]        req_other_vel_x,
   input  wire logic signed [31:0]        req_other_vel_y,
   output logic signed [31:0]             rsp_new_pos_x,
   output logic signed [31:0]             rsp_new_pos_y,
   output logic signed [31:0]             rsp_new_vel_x,
   output logic signed [31:0]             rsp_new_vel_y
);
   import kcr_pkg::*;

   logic signed [31:0] vx_ff, vy_ff, mx_ff, my_ff, ox_ff, oy_ff;
   logic signed [31:0] pcx_ff, pcx_in, pcy_ff, pcy_in, vcx_ff, vcx_in, vcy_ff, vcy_in;
   logic signed [63:0] sv_ff, so_ff, n_ff, d_ff, hold_ff, prod_ff, prod_in;
   logic signed [31:0] p_ff, p_in, q_ff, q_in, r_ff, r_in, ddp_ff, ddp_in;
   logic signed [31:0] opx_ff, opy_ff, ovx_ff, ovy_ff;
   logic signed [31:0] mul_a, mul_b;
   logic signed [63:0] dot_val, fl;
   logic signed [33:0] pq_sum;
   logic [63:0]        v_mag, c_mag, total, d_mag, div_num, div_den;
   logic [32:0]        quo;
   logic               div_done, quo_big;

   // shared multiplier, one product per cycle
   always_comb begin
      unique case (cmd.mul_sel)
         MS_VX_MX:  begin mul_a = vx_ff;  mul_b = mx_ff;  end
         MS_VY_MY:  begin mul_a = vy_ff;  mul_b = my_ff;  end
         MS_OX_MX:  begin mul_a = ox_ff;  mul_b = mx_ff;  end
         MS_OY_MY:  begin mul_a = oy_ff;  mul_b = my_ff;  end
         MS_MX_MX:  begin mul_a = mx_ff;  mul_b = mx_ff;  end
         MS_MY_MY:  begin mul_a = my_ff;  mul_b = my_ff;  end
         MS_PX_MX:  begin mul_a = pcx_ff; mul_b = mx_ff;  end
         MS_PY_MY:  begin mul_a = pcy_ff; mul_b = my_ff;  end
         MS_MX_DDP: begin mul_a = mx_ff;  mul_b = ddp_ff; end
         MS_MY_DDP: begin mul_a = my_ff;  mul_b = ddp_ff; end
         MS_MX_R:   begin mul_a = mx_ff;  mul_b = r_ff;   end
         MS_MY_R:   begin mul_a = my_ff;  mul_b = r_ff;   end
         MS_CX_MY:  begin mul_a = vcx_ff; mul_b = my_ff;  end
         MS_CY_MX:  begin mul_a = vcy_ff; mul_b = mx_ff;  end
         default:   begin mul_a = vx_ff;  mul_b = mx_ff;  end
      endcase
   end

   assign prod_in = mul_a * mul_b;
   assign dot_val = sat64(65'(hold_ff) + 65'(prod_ff));
   assign fl      = prod_ff >>> FRAC_BITS;

   assign v_mag = (sv_ff > 64'sd0) ? sv_ff : '0;
   assign c_mag = (so_ff < 64'sd0) ? 64'(-so_ff) : '0;
   assign total = v_mag + c_mag;
   assign d_mag = d_ff[63] ? 64'(-d_ff) : d_ff;

   always_comb begin
      unique case (cmd.div_src)
         DS_P:    begin div_num = v_mag; div_den = total; end
         DS_Q:    begin div_num = d_mag; div_den = n_ff;  end
         DS_R:    begin div_num = v_mag; div_den = n_ff;  end
         default: begin div_num = v_mag; div_den = n_ff;  end
      endcase
   end

   kcr_div #(.FRAC_BITS(FRAC_BITS)) u_div (
      .clock (clock),
      .reset (reset),
      .start (cmd.div_start),
      .num   (div_num),
      .den   (div_den),
      .done  (div_done),
      .quo   (quo)
   );

   assign quo_big = |quo[32:31];

   always_comb begin
      p_in = p_ff;
      q_in = q_ff;
      r_in = r_ff;
      if (cmd.p_default) begin
         // partner counts as stationary when either coordinate is zero
         p_in = (ox_ff == 32'sd0 || oy_ff == 32'sd0) ? 32'sd1 <<< FRAC_BITS
                                                     : 32'sd1 <<< (FRAC_BITS - 1);
      end else if (cmd.div_load) begin
         unique case (cmd.div_src)
            DS_P: p_in = quo[31:0];
            DS_Q: begin
               // magnitude of 2^31 and above negates to the floor
               if (d_ff[63]) q_in = quo_big ? MIN32 : -$signed(quo[31:0]);
               else          q_in = quo_big ? MAX32 : $signed(quo[31:0]);
            end
            DS_R: r_in = quo_big ? MAX32 : $signed(quo[31:0]);
            default: r_in = r_ff;
         endcase
      end
   end

   assign pq_sum = 34'(p_ff) + 34'(q_ff);

   always_comb begin
      ddp_in = ddp_ff;
      if (cmd.ddp_load) begin
         if (pq_sum < 34'sd0)             ddp_in = '0;
         else if (pq_sum > 34'(MAX32))    ddp_in = MAX32;
         else                             ddp_in = pq_sum[31:0];
      end
   end

   always_comb begin
      pcx_in = pcx_ff;
      pcy_in = pcy_ff;
      vcx_in = vcx_ff;
      vcy_in = vcy_ff;
      if (cmd.resolve) begin
         pcx_in = '0;
         pcy_in = '0;
         vcx_in = '0;
         vcy_in = '0;
      end
      if (cmd.pos_x_load)   pcx_in = sat32(66'(pcx_ff) - 66'(fl));
      if (cmd.pos_y_load)   pcy_in = sat32(66'(pcy_ff) - 66'(fl));
      if (cmd.velr_x_load)  vcx_in = sat32(-66'(fl));
      if (cmd.velr_y_load)  vcy_in = sat32(-66'(fl));
      if (cmd.vel_neg_load) begin
         vcx_in = sat32(-66'(vx_ff));
         vcy_in = sat32(-66'(vy_ff));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pcx_ff <= '0;
         pcy_ff <= '0;
         vcx_ff <= '0;
         vcy_ff <= '0;
      end else begin
         pcx_ff <= pcx_in;
         pcy_ff <= pcy_in;
         vcx_ff <= vcx_in;
         vcy_ff <= vcy_in;
      end
      prod_ff <= prod_in;
      p_ff    <= p_in;
      q_ff    <= q_in;
      r_ff    <= r_in;
      ddp_ff  <= ddp_in;
      if (cmd.hold) hold_ff <= prod_ff;
      unique case (cmd.dot_dst)
         DD_SV:   sv_ff <= dot_val;
         DD_SO:   so_ff <= dot_val;
         DD_N:    n_ff  <= dot_val;
         DD_D:    d_ff  <= dot_val;
         default: ;
      endcase
      if (cmd.capture) begin
         vx_ff <= req_self_vel_x;
         vy_ff <= req_self_vel_y;
         mx_ff <= req_mtv_x;
         my_ff <= req_mtv_y;
         ox_ff <= req_other_vel_x;
         oy_ff <= req_other_vel_y;
      end
      if (cmd.resolve) begin
         opx_ff <= sat32(66'(req_self_pos_x) + 66'(pcx_ff));
         opy_ff <= sat32(66'(req_self_pos_y) + 66'(pcy_ff));
         ovx_ff <= sat32(66'(req_self_vel_x) + 66'(vcx_ff));
         ovy_ff <= sat32(66'(req_self_vel_y) + 66'(vcy_ff));
      end
   end

   assign status.skip       = (req_self_vel_x == 32'sd0 && req_self_vel_y == 32'sd0) ||
                              (req_mtv_x == 32'sd0 && req_mtv_y == 32'sd0);
   assign status.total_zero = (total == 64'd0);
   assign status.vel_zero   = (vcx_ff == 32'sd0) && (vcy_ff == 32'sd0);
   assign status.v_pos      = (v_mag != 64'd0);
   assign status.cross_ne   = (hold_ff != prod_ff);
   assign status.div_done   = div_done;

   assign rsp_new_pos_x = opx_ff;
   assign rsp_new_pos_y = opy_ff;
   assign rsp_new_vel_x = ovx_ff;
   assign rsp_new_vel_y = ovy_ff;

endmodule

`default_nettype wire

/* sv/kcr_ctrl.sv */
// Controller state machine: sequences multiplies, divisions and updates.
// Depends on kcr_pkg.
`timescale 1ns / 1ps
`default_nettype none

module kcr_ctrl (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     req_valid,
   output logic                          req_stall,
   input  wire logic                     req_func,
   output logic                          rsp_valid,
   input  wire logic                     rsp_stall,
   input  wire kcr_pkg::kcr_status_type  status,
   output kcr_pkg::kcr_cmd_type          cmd
);
   import kcr_pkg::*;

   typedef enum logic [9:0] {
      S_IDLE     = 10'b00_0000_0001,
      S_DOT      = 10'b00_0000_0010,
      S_DIV_GO   = 10'b00_0000_0100,
      S_DIV_WAIT = 10'b00_0000_1000,
      S_DDP      = 10'b00_0001_0000,
      S_POS      = 10'b00_0010_0000,
      S_VEL_GO   = 10'b00_0100_0000,
      S_VMUL     = 10'b00_1000_0000,
      S_CROSS    = 10'b01_0000_0000,
      S_OUT      = 10'b10_0000_0000
   } state_type;

   state_type   state_ff, state_in;
   logic [3:0]  step_ff, step_in;
   div_src_type src_ff, src_in;
   logic        accept;

   assign req_stall = (state_ff != S_IDLE);
   assign rsp_valid = (state_ff == S_OUT);
   assign accept    = req_valid && !req_stall;

   always_comb begin
      state_in    = state_ff;
      step_in     = step_ff;
      src_in      = src_ff;
      cmd         = '0;
      cmd.div_src = src_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               if (req_func) begin
                  cmd.resolve = 1'b1;
                  state_in    = S_OUT;
               end else if (!status.skip) begin
                  cmd.capture = 1'b1;
                  step_in     = '0;
                  state_in    = S_DOT;
               end
            end
         end
         S_DOT: begin
            step_in = step_ff + 4'd1;
            unique case (step_ff)
               4'd0: cmd.mul_sel = MS_VX_MX;
               4'd1: begin cmd.mul_sel = MS_VY_MY; cmd.hold = 1'b1; end
               4'd2: begin cmd.mul_sel = MS_OX_MX; cmd.dot_dst = DD_SV; end
               4'd3: begin cmd.mul_sel = MS_OY_MY; cmd.hold = 1'b1; end
               4'd4: begin cmd.mul_sel = MS_MX_MX; cmd.dot_dst = DD_SO; end
               4'd5: begin cmd.mul_sel = MS_MY_MY; cmd.hold = 1'b1; end
               4'd6: begin cmd.mul_sel = MS_PX_MX; cmd.dot_dst = DD_N; end
               4'd7: begin cmd.mul_sel = MS_PY_MY; cmd.hold = 1'b1; end
               default: begin
                  cmd.dot_dst = DD_D;
                  src_in      = DS_P;
                  state_in    = S_DIV_GO;
               end
            endcase
         end
         S_DIV_GO: begin
            if (src_ff == DS_P && status.total_zero) begin
               cmd.p_default = 1'b1;
               src_in        = DS_Q;
            end else begin
               cmd.div_start = 1'b1;
               state_in      = S_DIV_WAIT;
            end
         end
         S_DIV_WAIT: begin
            if (status.div_done) begin
               cmd.div_load = 1'b1;
               unique case (src_ff)
                  DS_P: begin src_in = DS_Q; state_in = S_DIV_GO; end
                  DS_Q: state_in = S_DDP;
                  DS_R: begin step_in = '0; state_in = S_VMUL; end
                  default: state_in = S_IDLE;
               endcase
            end
         end
         S_DDP: begin
            cmd.ddp_load = 1'b1;
            step_in      = '0;
            state_in     = S_POS;
         end
         S_POS: begin
            step_in = step_ff + 4'd1;
            unique case (step_ff)
               4'd0: cmd.mul_sel = MS_MX_DDP;
               4'd1: begin cmd.mul_sel = MS_MY_DDP; cmd.pos_x_load = 1'b1; end
               default: begin cmd.pos_y_load = 1'b1; state_in = S_VEL_GO; end
            endcase
         end
         S_VEL_GO: begin
            step_in = '0;
            if (status.vel_zero) begin
               src_in   = DS_R;
               state_in = S_DIV_GO;
            end else if (status.v_pos) begin
               state_in = S_CROSS;
            end else begin
               state_in = S_IDLE;
            end
         end
         S_VMUL: begin
            step_in = step_ff + 4'd1;
            unique case (step_ff)
               4'd0: cmd.mul_sel = MS_MX_R;
               4'd1: begin cmd.mul_sel = MS_MY_R; cmd.velr_x_load = 1'b1; end
               default: begin cmd.velr_y_load = 1'b1; state_in = S_IDLE; end
            endcase
         end
         S_CROSS: begin
            step_in = step_ff + 4'd1;
            unique case (step_ff)
               4'd0: cmd.mul_sel = MS_CX_MY;
               4'd1: begin cmd.mul_sel = MS_CY_MX; cmd.hold = 1'b1; end
               default: begin
                  cmd.vel_neg_load = status.cross_ne;
                  state_in         = S_IDLE;
               end
            endcase
         end
         S_OUT: begin
            if (!rsp_stall) state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         step_ff  <= '0;
         src_ff   <= DS_P;
      end else begin
         state_ff <= state_in;
         step_ff  <= step_in;
         src_ff   <= src_in;
      end
   end

endmodule

`default_nettype wire

/* sv/kinematic_collision_resolver_unit.sv */
// Collision resolver top level. Resolve beat: result valid the cycle after accept.
// Collide beat: busy after accept (not busy if skipped) while the nine-step multiply
// sequence runs on the shared 32x32 multiplier, followed by up to three divider runs.
// One beat in flight at a time; req_stall is high until the beat is finished.
// Synchronous active-high reset clears the corrections and returns to idle.
// Depends on kcr_pkg, kcr_ctrl, kcr_dp (which holds kcr_div).
`timescale 1ns / 1ps
`default_nettype none

module kinematic_collision_resolver_unit #(
   parameter int FRAC_BITS = kcr_pkg::FRAC_BITS_DEF
) (
   input  wire logic               clock,
   input  wire logic               reset,
   // request channel
   input  wire logic               req_valid,
   output logic                    req_stall,
   input  wire logic               req_func,
   input  wire logic signed [31:0] req_self_vel_x,
   input  wire logic signed [31:0] req_self_vel_y,
   input  wire logic signed [31:0] req_self_pos_x,
   input  wire logic signed [31:0] req_self_pos_y,
   input  wire logic signed [31:0] req_mtv_x,
   input  wire logic signed [31:0] req_mtv_y,
   input  wire logic signed [31:0] req_other_vel_x,
   input  wire logic signed [31:0] req_other_vel_y,
   // response channel
   output logic                    rsp_valid,
   input  wire logic               rsp_stall,
   output logic signed [31:0]      rsp_new_pos_x,
   output logic signed [31:0]      rsp_new_pos_y,
   output logic signed [31:0]      rsp_new_vel_x,
   output logic signed [31:0]      rsp_new_vel_y
);
   import kcr_pkg::*;

   // command and status between sequencer and datapath
   kcr_cmd_type    cmd;
   kcr_status_type status;

   // Sequencer: accepts a beat only when idle. A collide beat with a zero
   // velocity or zero translation vector is taken and dropped at once.
   kcr_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_func  (req_func),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .status    (status),
      .cmd       (cmd)
   );

   // Datapath: dot products through one multiplier, share and projection
   // quotients through one divider, saturating updates of the corrections.
   // The resolve beat loads the output registers and clears the corrections.
   kcr_dp #(.FRAC_BITS(FRAC_BITS)) u_dp (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .status          (status),
      .req_self_vel_x  (req_self_vel_x),
      .req_self_vel_y  (req_self_vel_y),
      .req_self_pos_x  (req_self_pos_x),
      .req_self_pos_y  (req_self_pos_y),
      .req_mtv_x       (req_mtv_x),
      .req_mtv_y       (req_mtv_y),
      .req_other_vel_x (req_other_vel_x),
      .req_other_vel_y (req_other_vel_y),
      .rsp_new_pos_x   (rsp_new_pos_x),
      .rsp_new_pos_y   (rsp_new_pos_y),
      .rsp_new_vel_x   (rsp_new_vel_x),
      .rsp_new_vel_y   (rsp_new_vel_y)
   );

endmodule

`default_nettype wire
